/* rtl/ctok_pkg.sv */
// Shared types and constants for the C-style text tokenizer.
`default_nettype none
package ctok_pkg;

  localparam int MaxRes = 5;
  localparam int CntW   = $clog2(MaxRes + 1);

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_END    = 2'd1,
    KIND_UNTERM = 2'd2,
    KIND_EOT    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_LINE    = 3'd1,
    MODE_BLOCK   = 3'd2,
    MODE_BSTAR   = 3'd3,
    MODE_WORD    = 3'd4,
    MODE_QUOTED  = 3'd5,
    MODE_ESC     = 3'd6
  } mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    logic       quoted_token;
  } ent_t;

  typedef struct packed {
    ent_t [MaxRes-1:0]  ents;
    logic [CntW-1:0]    cnt;
  } batch_t;

endpackage
`default_nettype wire

/* rtl/ctok_in_if.sv */
// Input channel: one text byte per beat.
`default_nettype none
interface ctok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

/* rtl/ctok_out_if.sv */
// Output channel: one token result per beat.
`default_nettype none
interface ctok_out_if import ctok_pkg::*;;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] char_value;
  logic       quoted_token;
  logic       last;

  modport source (output valid, output kind, output char_value, output quoted_token,
                  output last, input ready);
  modport sink (input valid, input kind, input char_value, input quoted_token,
                input last, output ready);
endinterface
`default_nettype wire

/* rtl/ctok_dec.sv */
// Per-byte scanner step: next mode and the list of results one byte causes.
`default_nettype none
module ctok_dec import ctok_pkg::*; (
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  input  wire mode_t      mode,
  input  wire logic       slash_pending,
  output batch_t          batch,
  output mode_t           mode_next,
  output logic            slash_next
);

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBack  = 8'h5C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    logic p;
    case (b)
      8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3D, 8'h3B, 8'h3C, 8'h3E,
      8'h2C, 8'h28, 8'h29, 8'h26, 8'h2A: p = 1'b1;
      default: p = 1'b0;
    endcase
    return p;
  endfunction

  function automatic ent_t mk(input kind_t k, input logic [7:0] c, input logic q);
    ent_t e;
    e.kind         = k;
    e.char_value   = c;
    e.quoted_token = q;
    return e;
  endfunction

  mode_t           m;
  logic            sp;
  logic            do_word;
  logic [CntW-1:0] n;
  ent_t [MaxRes-1:0] res;

  always_comb begin
    res     = '0;
    n       = '0;
    do_word = 1'b0;
    m       = (mode > MODE_ESC) ? MODE_BETWEEN : mode;
    sp      = slash_pending && (m == MODE_BETWEEN || m == MODE_WORD);

    if (sp) begin
      sp = 1'b0;
      if (text_byte == ChSlash || text_byte == ChStar) begin
        if (m == MODE_WORD) begin
          res[n] = mk(KIND_END, 8'h00, 1'b0); n = n + CntW'(1);
        end
        m = (text_byte == ChSlash) ? MODE_LINE : MODE_BLOCK;
      end else begin
        res[n] = mk(KIND_CHAR, ChSlash, 1'b0); n = n + CntW'(1);
        m = MODE_WORD;
        do_word = 1'b1;
      end
    end else begin
      case (m)
        MODE_LINE: begin
          if (text_byte == ChLf) m = MODE_BETWEEN;
        end
        MODE_BLOCK: begin
          if (text_byte == ChStar) m = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (text_byte == ChSlash) m = MODE_BETWEEN;
          else if (text_byte != ChStar) m = MODE_BLOCK;
        end
        MODE_QUOTED: begin
          if (text_byte == ChQuote) begin
            res[n] = mk(KIND_END, 8'h00, 1'b1); n = n + CntW'(1);
            m = MODE_BETWEEN;
          end else if (text_byte == ChBack) begin
            m = MODE_ESC;
          end else begin
            res[n] = mk(KIND_CHAR, text_byte, 1'b1); n = n + CntW'(1);
          end
        end
        MODE_ESC: begin
          if (text_byte == ChN) res[n] = mk(KIND_CHAR, ChLf, 1'b1);
          else if (text_byte == ChR) res[n] = mk(KIND_CHAR, ChCr, 1'b1);
          else if (text_byte == ChT) res[n] = mk(KIND_CHAR, ChTab, 1'b1);
          else res[n] = mk(KIND_CHAR, text_byte, 1'b1);
          n = n + CntW'(1);
          m = MODE_QUOTED;
        end
        MODE_WORD: begin
          do_word = 1'b1;
        end
        default: begin
          if (is_space(text_byte)) begin
            m = MODE_BETWEEN;
          end else if (text_byte == ChSlash) begin
            sp = 1'b1;
          end else if (text_byte == ChQuote) begin
            m = MODE_QUOTED;
          end else if (is_punct(text_byte)) begin
            res[n] = mk(KIND_CHAR, text_byte, 1'b0); n = n + CntW'(1);
            res[n] = mk(KIND_END, 8'h00, 1'b0); n = n + CntW'(1);
          end else begin
            res[n] = mk(KIND_CHAR, text_byte, 1'b0); n = n + CntW'(1);
            m = MODE_WORD;
          end
        end
      endcase
    end

    if (do_word) begin
      if (is_space(text_byte)) begin
        res[n] = mk(KIND_END, 8'h00, 1'b0); n = n + CntW'(1);
        m = MODE_BETWEEN;
      end else if (is_punct(text_byte)) begin
        res[n] = mk(KIND_END, 8'h00, 1'b0); n = n + CntW'(1);
        res[n] = mk(KIND_CHAR, text_byte, 1'b0); n = n + CntW'(1);
        res[n] = mk(KIND_END, 8'h00, 1'b0); n = n + CntW'(1);
        m = MODE_BETWEEN;
      end else if (text_byte == ChSlash) begin
        sp = 1'b1;
      end else begin
        res[n] = mk(KIND_CHAR, text_byte, 1'b0); n = n + CntW'(1);
      end
    end

    if (end_of_text) begin
      if (sp && (m == MODE_BETWEEN || m == MODE_WORD)) begin
        res[n] = mk(KIND_CHAR, ChSlash, 1'b0); n = n + CntW'(1);
        m = MODE_WORD;
      end
      sp = 1'b0;
      if (m == MODE_WORD) begin
        res[n] = mk(KIND_END, 8'h00, 1'b0); n = n + CntW'(1);
      end else if (m == MODE_QUOTED || m == MODE_ESC) begin
        if (m == MODE_ESC) begin
          res[n] = mk(KIND_CHAR, ChBack, 1'b1); n = n + CntW'(1);
        end
        res[n] = mk(KIND_UNTERM, 8'h00, 1'b1); n = n + CntW'(1);
      end
      res[n] = mk(KIND_EOT, 8'h00, 1'b0); n = n + CntW'(1);
      m = MODE_BETWEEN;
    end
  end

  assign batch.ents = res;
  assign batch.cnt  = n;
  assign mode_next  = m;
  assign slash_next = sp;

endmodule
`default_nettype wire

/* rtl/ctok_rbuf.sv */
// Result register: holds one byte's results and hands them out one per beat.
`default_nettype none
module ctok_rbuf import ctok_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load,
  input  wire batch_t batch,
  input  wire logic   out_ready,
  output logic        in_ready,
  output logic        out_valid,
  output ent_t        head,
  output logic        head_last
);

  logic [CntW-1:0]   cnt;
  ent_t [MaxRes-1:0] ents;
  logic              pop;

  assign out_valid = (cnt != '0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt == '0) || (cnt == CntW'(1) && out_ready);
  assign head      = ents[0];
  assign head_last = (cnt == CntW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= batch.cnt;
    end else if (pop) begin
      cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ents <= batch.ents;
    end else if (pop) begin
      for (int i = 0; i < MaxRes - 1; i++) ents[i] <= ents[i+1];
      ents[MaxRes-1] <= '0;
    end
  end

endmodule
`default_nettype wire

/* rtl/c_style_text_tokenizer.sv */
// Top level of the streaming C-style text tokenizer.
//
// in_ch takes one text byte per beat, with end_of_text set on the final byte.
// out_ch gives token results, one per beat: token characters (kind 0), token
// ends (kind 1), an unterminated-string error (kind 2) and end of text (kind 3);
// last marks the final result caused by one input byte.
// A byte is scanned in the cycle it is accepted and its results (0 to 5) are
// registered, so the first result appears in the cycle after acceptance.
// A byte causing zero or one result leaves room for the next byte in the same
// cycle, so such text streams at one byte per cycle while out_ch is ready. A
// byte causing more results holds in_ch.ready low while the result register drains.
// If out_ch stalls, the held result stays on the port and in_ch waits while the
// result register holds any result.
// Reset (rst, synchronous) returns the scanner to between tokens, drops any
// held slash and empties the result register.
// After an end_of_text byte the scanner is back in its reset state.
`default_nettype none
module c_style_text_tokenizer import ctok_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  ctok_in_if.sink    in_ch,
  ctok_out_if.source out_ch
);

  mode_t  mode;
  mode_t  mode_next;
  logic   slash_pending;
  logic   slash_next;
  batch_t batch;
  ent_t   head;
  logic   accept;

  assign accept = in_ch.valid && in_ch.ready;

  ctok_dec u_dec (
    .text_byte     (in_ch.text_byte),
    .end_of_text   (in_ch.end_of_text),
    .mode          (mode),
    .slash_pending (slash_pending),
    .batch         (batch),
    .mode_next     (mode_next),
    .slash_next    (slash_next)
  );

  ctok_rbuf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .batch     (batch),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .head      (head),
    .head_last (out_ch.last)
  );

  assign out_ch.kind         = head.kind;
  assign out_ch.char_value   = head.char_value;
  assign out_ch.quoted_token = head.quoted_token;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_BETWEEN;
      slash_pending <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      slash_pending <= slash_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/ctok_chk.sv */
// Port-level checks for the tokenizer, bound to the top level.
`default_nettype none
module ctok_chk import ctok_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire kind_t      kind,
  input wire logic [7:0] char_value,
  input wire logic       quoted_token,
  input wire logic       last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  a_eot_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_EOT) |-> (last && !quoted_token))
    else $error("end of text is not the final beat of its byte");

  a_unterm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_UNTERM) |-> (quoted_token && !last))
    else $error("unterminated string beat malformed");

  a_mark_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_CHAR) |-> (char_value == 8'h00))
    else $error("mark beat carries a character");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(kind) && $stable(char_value) && $stable(last)))
    else $error("stalled result beat changed");

endmodule

bind c_style_text_tokenizer ctok_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .kind         (out_ch.kind),
  .char_value   (out_ch.char_value),
  .quoted_token (out_ch.quoted_token),
  .last         (out_ch.last)
);
`default_nettype wire

/* test/c_style_text_tokenizer_tb.sv */
// Testbench for c_style_text_tokenizer: directed and random text checked against a token predictor.
`timescale 1ns / 100ps
module c_style_text_tokenizer_tb;
  import ctok_pkg::*;

  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_QUOTE  = "\"";
  localparam logic [7:0] CH_BSLASH = "\\";
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] CH_R      = "r";
  localparam logic [7:0] CH_T      = "t";

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    logic       quoted_token;
    logic       last;
  } tok_t;

  logic clk;
  logic rst;

  ctok_in_if  in_ch ();
  ctok_out_if out_ch ();

  c_style_text_tokenizer u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mode_t       scan_st;
  logic        slash_held;
  tok_t        step_q[$];
  tok_t        token_q[$];
  logic [7:0]  text_q[$];
  int          errors;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int          rx_hold_cycles;
  string       punct_set = "{}[]=;<>,()&*";

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("c_style_text_tokenizer verification failed");
    $finish;
  end

  // ---------------- token predictor ----------------
  function automatic bit is_ws(input logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit is_punct(input logic [7:0] b);
    case (b)
      "{", "}", "[", "]", "=", ";", "<", ">", ",", "(", ")", "&", "*": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void add_tok(input kind_t k, input logic [7:0] c, input logic q);
    tok_t t;
    if (step_q.size() < MaxRes) begin
      t.kind = k;
      t.char_value = c;
      t.quoted_token = q;
      t.last = 1'b0;
      step_q = {step_q, t};
    end
  endfunction

  function automatic void word_byte(input logic [7:0] b);
    if (is_ws(b)) begin
      add_tok(KIND_END, 8'd0, 1'b0);
      scan_st = MODE_BETWEEN;
    end else if (is_punct(b)) begin
      add_tok(KIND_END, 8'd0, 1'b0);
      add_tok(KIND_CHAR, b, 1'b0);
      add_tok(KIND_END, 8'd0, 1'b0);
      scan_st = MODE_BETWEEN;
    end else if (b == CH_SLASH) begin
      slash_held = 1'b1;
    end else begin
      add_tok(KIND_CHAR, b, 1'b0);
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    if (scan_st != MODE_BETWEEN && scan_st != MODE_WORD) slash_held = 1'b0;
    if (slash_held) begin
      slash_held = 1'b0;
      if (b == CH_SLASH || b == CH_STAR) begin
        if (scan_st == MODE_WORD) add_tok(KIND_END, 8'd0, 1'b0);
        if (b == CH_SLASH) scan_st = MODE_LINE;
        else scan_st = MODE_BLOCK;
      end else begin
        add_tok(KIND_CHAR, CH_SLASH, 1'b0);
        scan_st = MODE_WORD;
        word_byte(b);
      end
    end else begin
      case (scan_st)
        MODE_LINE: begin
          if (b == CH_NL) scan_st = MODE_BETWEEN;
        end
        MODE_BLOCK: begin
          if (b == CH_STAR) scan_st = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (b == CH_SLASH) scan_st = MODE_BETWEEN;
          else if (b != CH_STAR) scan_st = MODE_BLOCK;
        end
        MODE_QUOTED: begin
          if (b == CH_QUOTE) begin
            add_tok(KIND_END, 8'd0, 1'b1);
            scan_st = MODE_BETWEEN;
          end else if (b == CH_BSLASH) begin
            scan_st = MODE_ESC;
          end else begin
            add_tok(KIND_CHAR, b, 1'b1);
          end
        end
        MODE_ESC: begin
          case (b)
            CH_N:    add_tok(KIND_CHAR, CH_NL, 1'b1);
            CH_R:    add_tok(KIND_CHAR, CH_CR, 1'b1);
            CH_T:    add_tok(KIND_CHAR, CH_TAB, 1'b1);
            default: add_tok(KIND_CHAR, b, 1'b1);
          endcase
          scan_st = MODE_QUOTED;
        end
        MODE_WORD: word_byte(b);
        default: begin
          if (is_ws(b)) begin
          end else if (b == CH_SLASH) begin
            slash_held = 1'b1;
          end else if (b == CH_QUOTE) begin
            scan_st = MODE_QUOTED;
          end else if (is_punct(b)) begin
            add_tok(KIND_CHAR, b, 1'b0);
            add_tok(KIND_END, 8'd0, 1'b0);
          end else begin
            add_tok(KIND_CHAR, b, 1'b0);
            scan_st = MODE_WORD;
          end
        end
      endcase
    end
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b, input logic eot);
    tok_t t;
    step_q.delete();
    scan_byte(b);
    if (eot) begin
      if (slash_held && (scan_st == MODE_BETWEEN || scan_st == MODE_WORD)) begin
        add_tok(KIND_CHAR, CH_SLASH, 1'b0);
        scan_st = MODE_WORD;
      end
      slash_held = 1'b0;
      if (scan_st == MODE_WORD) begin
        add_tok(KIND_END, 8'd0, 1'b0);
      end else if (scan_st == MODE_QUOTED || scan_st == MODE_ESC) begin
        if (scan_st == MODE_ESC) add_tok(KIND_CHAR, CH_BSLASH, 1'b1);
        add_tok(KIND_UNTERM, 8'd0, 1'b1);
      end
      add_tok(KIND_EOT, 8'd0, 1'b0);
      scan_st = MODE_BETWEEN;
    end
    if (step_q.size() > 0) begin
      t = step_q[step_q.size() - 1];
      t.last = 1'b1;
      step_q[step_q.size() - 1] = t;
    end
    token_q = {token_q, step_q};
    step_q.delete();
  endfunction

  // ---------------- result checking ----------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    tok_t t;
    if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (token_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected beat, expected none, actual kind %0d char %0h",
                 $time, out_ch.kind, out_ch.char_value);
      end else begin
        t = token_q.pop_front();
        check_field("kind", 8'(t.kind), 8'(out_ch.kind));
        check_field("char_value", t.char_value, out_ch.char_value);
        check_field("quoted_token", 8'(t.quoted_token), 8'(out_ch.quoted_token));
        check_field("last", 8'(t.last), 8'(out_ch.last));
      end
    end
  end

  // ---------------- receiver ----------------
  initial begin : drive_ready
    int n;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = rx_idle_en ? $urandom_range(0, 16) : 0;
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1 && rx_hold_cycles == 0);
    end
  end

  // ---------------- sender ----------------
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int n;
    n = tx_idle_en ? $urandom_range(0, 16) : 0;
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tokenize_byte(b, eot);
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic void add_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_fragment();
    int n;
    int i;
    case ($urandom_range(0, 9))
      0, 1: begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 7))
            0: add_byte(CH_SLASH);
            1: add_byte(CH_QUOTE);
            default: add_byte(8'("a") + 8'($urandom_range(0, 25)));
          endcase
        end
      end
      2: add_byte(punct_set[$urandom_range(0, 12)]);
      3: begin
        n = $urandom_range(0, 5);
        add_byte(n == 0 ? 8'd32 : 8'(8 + n));
      end
      4, 5: begin
        add_byte(CH_QUOTE);
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 5))
            0: begin
              add_byte(CH_BSLASH);
              case ($urandom_range(0, 3))
                0: add_byte(CH_N);
                1: add_byte(CH_R);
                2: add_byte(CH_T);
                default: add_byte(8'($urandom_range(0, 255)));
              endcase
            end
            1: add_byte(8'($urandom_range(0, 255)));
            default: add_byte(8'($urandom_range(32, 126)));
          endcase
        end
        if ($urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
      end
      6: begin
        add_str("//");
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) add_byte(8'($urandom_range(32, 126)));
        add_byte(CH_NL);
      end
      7: begin
        add_str("/*");
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: add_byte(CH_STAR);
            1: add_byte(CH_SLASH);
            default: add_byte(8'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 9) != 0) add_str("*/");
      end
      8: add_byte(8'($urandom_range(0, 255)));
      default: add_byte(8'd32);
    endcase
  endtask

  // ---------------- tests ----------------
  task automatic test_words_punct_extremes();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    // held slash inside a word, quote inside a word, punct, byte extremes, slash at end
    add_str("a/b\"{");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_str("/");
    send_text();
  endtask

  task automatic test_quoted_strings();
    // empty string, all escapes, escaped quote, then open string at end of text
    add_str("\"\"\"\\n\\r\\t\\\"a");
    send_text();
    // backslash as the final byte inside a string
    add_str("\"\\");
    send_text();
  endtask

  task automatic test_comments();
    // line comment, closed block comment, then one left open at end of text
    add_str("//c\n/**//*z");
    send_text();
  endtask

  task automatic test_backpressure();
    int i;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold_cycles = 200;
    for (i = 0; i < 40; i++) add_byte(punct_set[$urandom_range(0, 12)]);
    send_text();
  endtask

  task automatic test_random_text();
    int sent;
    int frags;
    sent = 0;
    while (sent < 90) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      frags = $urandom_range(1, 8);
      repeat (frags) add_fragment();
      sent += text_q.size();
      send_text();
    end
  endtask

  initial begin
    errors         = 0;
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    rx_hold_cycles = 0;
    scan_st        = MODE_BETWEEN;
    slash_held     = 1'b0;
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.text_byte   <= 8'd0;
    in_ch.end_of_text <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_words_punct_extremes();
    test_quoted_strings();
    test_comments();
    test_backpressure();
    test_random_text();

    in_ch.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("c_style_text_tokenizer verification clean");
    end else begin
      $display("c_style_text_tokenizer verification failed");
    end
    $finish;
  end

endmodule
